@@ rtl/bopf_pkg.sv @@
// ----------------------------------------------------------------------------
// Optimal page replacement fault counter: shared package
// Field widths, default sizes and the beat types of the input and result
// channels.
// ----------------------------------------------------------------------------
`default_nettype none

package bopf_pkg;

    localparam int PAGE_W        = 4;
    localparam int FRAME_W       = 5;
    localparam int FAULT_W       = 11;
    localparam int DEF_MAX_REFS  = 1024;
    localparam int DEF_NUM_PAGES = 16;

    localparam logic [FRAME_W-1:0] FRAME_RST = 5'd3;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              last_ref;
    } t_in;

    typedef struct packed {
        logic [FAULT_W-1:0] fault_count;
        logic               overflow;
    } t_out;

endpackage

`default_nettype wire

@@ rtl/bopf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bopf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/belady_optimal_page_faults_core.sv @@
// ----------------------------------------------------------------------------
// Optimal (MIN) page replacement fault counter
// Stores a reference string and counts the faults of optimal replacement.
// ----------------------------------------------------------------------------
// References are loaded at one beat per cycle into a memory of MAX_REFS
// entries with one write and one read port, until a beat with last_ref set;
// references beyond MAX_REFS set the overflow flag and are dropped. The run
// then replays the string through the one memory read port: each reference
// is read in one state and checked for a hit or a fault in the next, and a
// fault that evicts also scans ahead one stored reference per cycle until
// the farthest resident page is known, at most through the rest of the
// string. The result sits in its own register, so the next string loads
// while it waits; a run that ends while the earlier result is still unread
// holds until that beat is taken. No input is taken during a run.
// Configuration writes are taken only while the block is loading and apply
// to the string being loaded.
`default_nettype none

module belady_optimal_page_faults_core
    import bopf_pkg::*;
#(
    parameter int MAX_REFS  = DEF_MAX_REFS,
    parameter int NUM_PAGES = DEF_NUM_PAGES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [FRAME_W-1:0] i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in                i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out                    o_out_data
);

    localparam int AW = $clog2(MAX_REFS);
    localparam int LW = $clog2(MAX_REFS + 1);
    localparam int PW = $clog2(NUM_PAGES);

    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_REFS);
    localparam logic [6:0]    NP7     = 7'(NUM_PAGES);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [FRAME_W-1:0]   r_frames;
    logic [LW-1:0]        r_len, n_len;
    logic                 r_ovf, n_ovf;
    logic [LW-1:0]        r_i, n_i;
    logic [LW-1:0]        r_j, n_j;
    logic                 r_pend, n_pend;
    logic [NUM_PAGES-1:0] r_res, n_res;
    logic [NUM_PAGES-1:0] r_cand, n_cand;
    logic [FRAME_W-1:0]   r_used, n_used;
    logic [FAULT_W-1:0]   r_faults, n_faults;
    logic [PW-1:0]        r_page, n_page;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;

    logic [6:0]           mod_val;
    logic [PW-1:0]        in_page;
    logic                 in_beat;
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [PW-1:0]        ram_rdata;
    logic [FRAME_W-1:0]   frames_eff;
    logic [NUM_PAGES-1:0] rd_hot;
    logic [NUM_PAGES-1:0] page_hot;
    logic [NUM_PAGES-1:0] cand_left;
    logic [NUM_PAGES-1:0] cand_low;
    logic                 scan_issue;
    logic                 out_free;

    // Page number reduced modulo the page space by repeated subtraction.
    always_comb begin
        mod_val = {3'b000, i_in_data.page};
        for (int k = 0; k < 8; k++) begin
            if (mod_val >= NP7) begin
                mod_val = mod_val - NP7;
            end
        end
    end

    assign in_page     = mod_val[PW-1:0];
    assign o_in_ready  = (r_state == ST_LOAD);
    assign in_beat     = i_in_valid && o_in_ready;
    assign ram_we      = in_beat && (r_len < LEN_MAX);
    assign o_cfg_ready = (r_state == ST_LOAD);

    assign frames_eff = (r_frames == '0) ? FRAME_W'(1) : r_frames;
    assign rd_hot     = NUM_PAGES'(1) << ram_rdata;
    assign page_hot   = NUM_PAGES'(1) << r_page;
    assign cand_left  = r_cand & ~rd_hot;
    assign cand_low   = r_cand & (~r_cand + NUM_PAGES'(1));
    assign scan_issue = (r_j < r_len);
    assign ram_raddr  = (r_state == ST_SCAN) ? r_j[AW-1:0] : r_i[AW-1:0];
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    bopf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_REFS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (in_page),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_pend      = r_pend;
        n_res       = r_res;
        n_cand      = r_cand;
        n_used      = r_used;
        n_faults    = r_faults;
        n_page      = r_page;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            ST_LOAD: begin
                if (in_beat) begin
                    if (r_len < LEN_MAX) begin
                        n_len = r_len + LW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last_ref) begin
                        n_state  = ST_RD;
                        n_i      = '0;
                        n_res    = '0;
                        n_used   = '0;
                        n_faults = '0;
                    end
                end
            end
            ST_RD: begin
                n_state = (r_i < r_len) ? ST_CHK : ST_OUT;
            end
            ST_CHK: begin
                n_page = ram_rdata;
                if (r_res[ram_rdata]) begin
                    n_i     = r_i + LW'(1);
                    n_state = ST_RD;
                end else begin
                    n_faults = r_faults + FAULT_W'(1);
                    if (r_used < frames_eff) begin
                        n_used  = r_used + FRAME_W'(1);
                        n_res   = r_res | rd_hot;
                        n_i     = r_i + LW'(1);
                        n_state = ST_RD;
                    end else begin
                        n_j     = r_i + LW'(1);
                        n_cand  = r_res;
                        n_pend  = 1'b0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_pend = scan_issue;
                if (scan_issue) begin
                    n_j = r_j + LW'(1);
                end
                if (r_pend && (cand_left == '0)) begin
                    // The last candidate has just been seen: its next use is farthest.
                    n_res   = (r_res & ~rd_hot) | page_hot;
                    n_i     = r_i + LW'(1);
                    n_state = ST_RD;
                end else if (r_pend) begin
                    n_cand = cand_left;
                end else if (!scan_issue) begin
                    // The pages left are never used again.
                    n_res   = (r_res & ~cand_low) | page_hot;
                    n_i     = r_i + LW'(1);
                    n_state = ST_RD;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.fault_count = r_faults;
                    n_out.overflow    = r_ovf;
                    n_len             = '0;
                    n_ovf             = 1'b0;
                    n_state           = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_frames    <= FRAME_RST;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_pend      <= 1'b0;
            r_res       <= '0;
            r_used      <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_frames <= i_cfg_data;
            end
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_pend      <= n_pend;
            r_res       <= n_res;
            r_used      <= n_used;
            r_faults    <= n_faults;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_cand <= n_cand;
        r_page <= n_page;
    end

endmodule

`default_nettype wire
